>>> rtl/core/link_recovery_backoff_keepalive_assert.svh
// ----------------------------------------------------------------------------
// Link recovery assertion macros
// Shared property forms for the link recovery supervisor checkers.
// ----------------------------------------------------------------------------
`ifndef LINK_RECOVERY_BACKOFF_KEEPALIVE_ASSERT_SVH
`define LINK_RECOVERY_BACKOFF_KEEPALIVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LRBK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LRBK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lrbk_pkg.sv
// ----------------------------------------------------------------------------
// Link recovery package
// Types, codes and reset constants shared by the link recovery supervisor.
// ----------------------------------------------------------------------------
package lrbk_pkg;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_RECONNECT   = 3'd1,
        OP_CONNECT_OUT = 3'd2,
        OP_SEND_REQ    = 3'd3,
        OP_SEND_OUT    = 3'd4,
        OP_RECV_OUT    = 3'd5,
        OP_PONG        = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_FATAL     = 2'd1,
        ERR_TRANSIENT = 2'd2,
        ERR_OTHER     = 2'd3
    } err_class_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_RECONNECT,
        CMD_CONNECT_OK,
        CMD_CONNECT_FAIL,
        CMD_SEND,
        CMD_SEND_FATAL,
        CMD_SEND_BLOCK,
        CMD_RX_CLOSED,
        CMD_RX_ERROR,
        CMD_PONG
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_TRANSMIT = 3'd1,
        ACT_QUEUE    = 3'd2,
        ACT_PING     = 3'd3,
        ACT_CONNECT  = 3'd4,
        ACT_FLUSH    = 3'd5,
        ACT_GIVE_UP  = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        LINK_DISCONNECTED = 3'd0,
        LINK_CONNECTING   = 3'd1,
        LINK_CONNECTED    = 3'd2,
        LINK_ERROR        = 3'd3,
        LINK_RECONNECTING = 3'd4
    } link_t;

    typedef enum logic [2:0] {
        REG_START_DELAY = 3'd0,
        REG_DELAY_CAP   = 3'd1,
        REG_RETRY_LIMIT = 3'd2,
        REG_KA_PERIOD   = 3'd3,
        REG_KA_GRACE    = 3'd4
    } reg_addr_t;

    typedef struct packed {
        logic [15:0] start_delay;
        logic [15:0] delay_cap;
        logic [7:0]  retry_limit;
        logic [7:0]  ka_period;
        logic [7:0]  ka_grace;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] delay_ms;
        link_t       link_state;
        logic [7:0]  attempts;
        logic        gave_up;
    } result_t;

    localparam logic [15:0] START_DELAY_RST = 16'd1000;
    localparam logic [15:0] DELAY_CAP_RST   = 16'd32000;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd10;
    localparam logic [7:0]  KA_PERIOD_RST   = 8'd30;
    localparam logic [7:0]  KA_GRACE_RST    = 8'd10;

    localparam logic [7:0]  PING_AGE_MAX = 8'hFF;
    localparam logic [8:0]  PONG_AGE_MAX = 9'h1FF;
    localparam logic [7:0]  RETRY_MAX    = 8'hFF;

endpackage

>>> rtl/core/lrbk_queue.sv
// ----------------------------------------------------------------------------
// Link recovery command queue
// Small register FIFO between the request classifier and the executor.
// ----------------------------------------------------------------------------
module lrbk_queue #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/lrbk_front.sv
// ----------------------------------------------------------------------------
// Link recovery front end
// Accepts event requests and reduces them to executor commands.
// ----------------------------------------------------------------------------
module lrbk_front
    import lrbk_pkg::*;
(
    input  logic       in_valid,
    input  logic [2:0] operation,
    input  logic       success,
    input  logic [1:0] error_class,
    input  logic       q_full,
    output logic       in_stall,
    output logic       push,
    output cmd_t       push_cmd
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_cmd = CMD_NOP;
        unique case (operation)
            OP_TICK:        push_cmd = CMD_TICK;
            OP_RECONNECT:   push_cmd = CMD_RECONNECT;
            OP_CONNECT_OUT: push_cmd = success ? CMD_CONNECT_OK : CMD_CONNECT_FAIL;
            OP_SEND_REQ:    push_cmd = CMD_SEND;
            OP_SEND_OUT:
            begin
                unique case (error_class)
                    ERR_FATAL:     push_cmd = CMD_SEND_FATAL;
                    ERR_TRANSIENT: push_cmd = CMD_SEND_BLOCK;
                    default:       push_cmd = CMD_NOP;
                endcase
            end
            OP_RECV_OUT:
            begin
                unique case (error_class)
                    ERR_FATAL: push_cmd = CMD_RX_CLOSED;
                    ERR_OTHER: push_cmd = CMD_RX_ERROR;
                    default:   push_cmd = CMD_NOP;
                endcase
            end
            OP_PONG:        push_cmd = CMD_PONG;
            default:        push_cmd = CMD_NOP;
        endcase
    end

endmodule

>>> rtl/core/lrbk_back.sv
// ----------------------------------------------------------------------------
// Link recovery executor
// Applies commands to link, retry, backoff and keepalive state; holds result.
// ----------------------------------------------------------------------------
module lrbk_back
    import lrbk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t result
);

    link_t       link_reg;
    link_t       link_next;
    logic [7:0]  retry_reg;
    logic [7:0]  retry_next;
    logic [15:0] backoff_reg;
    logic [15:0] backoff_next;
    logic [7:0]  ping_age_reg;
    logic [7:0]  ping_age_next;
    logic [8:0]  pong_age_reg;
    logic [8:0]  pong_age_next;
    logic        gave_up_reg;
    logic        gave_up_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    result_t     result_next;

    logic        up;
    logic [7:0]  ping_inc;
    logic [8:0]  pong_inc;
    logic [8:0]  dead_limit;
    logic [16:0] doubled;
    action_t     action;
    logic [15:0] delay;

    assign q_pop     = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign up         = (link_reg == LINK_CONNECTED);
    assign ping_inc   = (ping_age_reg == PING_AGE_MAX) ? ping_age_reg : ping_age_reg + 1'b1;
    assign pong_inc   = (pong_age_reg == PONG_AGE_MAX) ? pong_age_reg : pong_age_reg + 1'b1;
    assign dead_limit = {1'b0, cfg.ka_period} + {1'b0, cfg.ka_grace};
    assign doubled    = {backoff_reg, 1'b0};

    always_comb
    begin
        link_next     = link_reg;
        retry_next    = retry_reg;
        backoff_next  = backoff_reg;
        ping_age_next = ping_age_reg;
        pong_age_next = pong_age_reg;
        gave_up_next  = gave_up_reg;
        action        = ACT_NONE;
        delay         = '0;
        unique case (q_cmd)
            CMD_TICK:
            begin
                if (up)
                begin
                    ping_age_next = ping_inc;
                    pong_age_next = pong_inc;
                    if (ping_inc >= cfg.ka_period)
                    begin
                        action        = ACT_PING;
                        ping_age_next = '0;
                    end
                    if (pong_inc > dead_limit)
                    begin
                        link_next = LINK_ERROR;
                    end
                end
            end
            CMD_RECONNECT:
            begin
                if (gave_up_reg || (retry_reg >= cfg.retry_limit))
                begin
                    gave_up_next = 1'b1;
                    action       = ACT_GIVE_UP;
                end
                else
                begin
                    link_next = LINK_RECONNECTING;
                    action    = ACT_CONNECT;
                    delay     = backoff_reg;
                end
            end
            CMD_CONNECT_OK:
            begin
                if (link_reg == LINK_RECONNECTING)
                begin
                    link_next     = LINK_CONNECTED;
                    retry_next    = '0;
                    backoff_next  = cfg.start_delay;
                    ping_age_next = '0;
                    pong_age_next = '0;
                    action        = ACT_FLUSH;
                end
            end
            CMD_CONNECT_FAIL:
            begin
                if (link_reg == LINK_RECONNECTING)
                begin
                    retry_next   = (retry_reg == RETRY_MAX) ? retry_reg : retry_reg + 1'b1;
                    backoff_next = (doubled > {1'b0, cfg.delay_cap}) ? cfg.delay_cap
                                                                      : doubled[15:0];
                    link_next    = LINK_ERROR;
                end
            end
            CMD_SEND:
            begin
                action = up ? ACT_TRANSMIT : ACT_QUEUE;
            end
            CMD_SEND_FATAL:
            begin
                if (up)
                begin
                    link_next = LINK_ERROR;
                    action    = ACT_QUEUE;
                end
            end
            CMD_SEND_BLOCK:
            begin
                if (up)
                begin
                    action = ACT_QUEUE;
                end
            end
            CMD_RX_CLOSED:
            begin
                if (up)
                begin
                    link_next = LINK_DISCONNECTED;
                end
            end
            CMD_RX_ERROR:
            begin
                if (up)
                begin
                    link_next = LINK_ERROR;
                end
            end
            CMD_PONG:
            begin
                if (up)
                begin
                    pong_age_next = '0;
                end
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase

        result_next.action     = action;
        result_next.delay_ms   = delay;
        result_next.link_state = link_next;
        result_next.attempts   = retry_next;
        result_next.gave_up    = gave_up_next;

        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg      <= LINK_DISCONNECTED;
            retry_reg     <= '0;
            backoff_reg   <= START_DELAY_RST;
            ping_age_reg  <= '0;
            pong_age_reg  <= '0;
            gave_up_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                link_reg     <= link_next;
                retry_reg    <= retry_next;
                backoff_reg  <= backoff_next;
                ping_age_reg <= ping_age_next;
                pong_age_reg <= pong_age_next;
                gave_up_reg  <= gave_up_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> rtl/core/link_recovery_backoff_keepalive.sv
// ----------------------------------------------------------------------------
// Link recovery supervisor
// Exponential backoff reconnect with keepalive, one event request per cycle unless stalled.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   input     in_valid / in_stall  operation, success, error_class
//   output    out_valid/out_stall  action, delay_ms, link_state, attempts,
//                                  gave_up_flag
//   config    APB write/read       start_delay, delay_cap, retry_limit,
//                                  ka_period, ka_grace
//
// One request per cycle sustained while out_stall is low; an accepted request
// passes the command queue write, then the executor result register.
// in_stall rises only when the QUEUE_DEPTH-entry command queue is full.
// Reset is asynchronous and needs no clearing pass; out_stall holds the result
// register and backs up into the queue.
// ----------------------------------------------------------------------------
module link_recovery_backoff_keepalive
    import lrbk_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic        success,
    input  logic [1:0]  error_class,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [15:0] delay_ms,
    output logic [2:0]  link_state,
    output logic [7:0]  attempts,
    output logic        gave_up_flag,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    cfg_write;
    logic    q_full;
    logic    q_empty;
    logic    q_push;
    cmd_t    q_push_cmd;
    logic    q_pop;
    cmd_t    q_pop_cmd;
    result_t result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (paddr[4:2])
            REG_START_DELAY:
            begin
                prdata = {16'd0, cfg_reg.start_delay};
                if (cfg_write)
                begin
                    cfg_next.start_delay = pwdata[15:0];
                end
            end
            REG_DELAY_CAP:
            begin
                prdata = {16'd0, cfg_reg.delay_cap};
                if (cfg_write)
                begin
                    cfg_next.delay_cap = pwdata[15:0];
                end
            end
            REG_RETRY_LIMIT:
            begin
                prdata = {24'd0, cfg_reg.retry_limit};
                if (cfg_write)
                begin
                    cfg_next.retry_limit = pwdata[7:0];
                end
            end
            REG_KA_PERIOD:
            begin
                prdata = {24'd0, cfg_reg.ka_period};
                if (cfg_write)
                begin
                    cfg_next.ka_period = pwdata[7:0];
                end
            end
            REG_KA_GRACE:
            begin
                prdata = {24'd0, cfg_reg.ka_grace};
                if (cfg_write)
                begin
                    cfg_next.ka_grace = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay <= START_DELAY_RST;
            cfg_reg.delay_cap   <= DELAY_CAP_RST;
            cfg_reg.retry_limit <= RETRY_LIMIT_RST;
            cfg_reg.ka_period   <= KA_PERIOD_RST;
            cfg_reg.ka_grace    <= KA_GRACE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lrbk_front u_front (
        .in_valid    (in_valid),
        .operation   (operation),
        .success     (success),
        .error_class (error_class),
        .q_full      (q_full),
        .in_stall    (in_stall),
        .push        (q_push),
        .push_cmd    (q_push_cmd)
    );

    lrbk_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_cmd),
        .empty     (q_empty)
    );

    lrbk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (!q_empty),
        .q_cmd     (q_pop_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign action       = result.action;
    assign delay_ms     = result.delay_ms;
    assign link_state   = result.link_state;
    assign attempts     = result.attempts;
    assign gave_up_flag = result.gave_up;

endmodule

>>> rtl/core/lrbk_checker.sv
// ----------------------------------------------------------------------------
// Link recovery port checker
// Watches the supervisor ports for result consistency and stall behavior.
// ----------------------------------------------------------------------------
`include "link_recovery_backoff_keepalive_assert.svh"

module lrbk_checker
    import lrbk_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  action,
    input logic [15:0] delay_ms,
    input logic [2:0]  link_state,
    input logic [7:0]  attempts,
    input logic        gave_up_flag
);

    `LRBK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(action) && $stable(delay_ms) && $stable(link_state) && $stable(attempts) && $stable(gave_up_flag), "stalled result changed")

    `LRBK_ASSERT_NOW(a_delay_only_connect, out_valid && (action != ACT_CONNECT), delay_ms == 16'd0, "delay without connect action")

    `LRBK_ASSERT_NOW(a_give_up_flag, out_valid && (action == ACT_GIVE_UP), gave_up_flag, "give up without flag")

    `LRBK_ASSERT_NOW(a_flush_connected, out_valid && (action == ACT_FLUSH), (link_state == LINK_CONNECTED) && (attempts == 8'd0), "flush outside fresh connection")

endmodule

bind link_recovery_backoff_keepalive lrbk_checker u_lrbk_checker (.*);
